// ===== hdl/rscd_pkg.sv =====
// Shared types, constants and codes of the run-length sprite clip decoder.
package rscd_pkg;

    // Width of the screen coordinates on the result ports.
    localparam int COORD_BITS = 12;

    localparam int BYTE_W  = 8;
    localparam int COL_W   = 13;
    localparam int ROW_W   = 12;
    localparam int RUN_W   = 9;
    localparam int LEN_W   = 9;
    localparam int PIX_W   = 8;
    localparam int ORG_W   = 12;
    localparam int WIN_W   = 13;
    localparam int SROWS_W = 12;

    // Signed width for the clipping arithmetic; holds 2^16 plus a sign bit.
    localparam int ARITH_W = 18;
    localparam logic signed [ARITH_W-1:0] COORD_CAP = ARITH_W'(1 << COORD_BITS);

    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
    localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

    // Command queue between front and back; the depth is a power of two.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Stream opcodes.
    localparam logic [BYTE_W-1:0] OP_FINISHED  = 8'd0;
    localparam logic [BYTE_W-1:0] OP_END_LINE  = 8'd1;
    localparam logic [BYTE_W-1:0] OP_COPY      = 8'd2;
    localparam logic [BYTE_W-1:0] OP_SKIP      = 8'd3;
    localparam logic [BYTE_W-1:0] OP_DUPLICATE = 8'd4;

    // Configuration register indexes and port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SPRITE_ROWS   = 3'd4;
    localparam logic [2:0] REG_MONO_ENABLE   = 3'd5;
    localparam logic [2:0] REG_MONO_COLOUR   = 3'd6;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_COPY_CNT,
        PH_COPY_DATA,
        PH_SKIP_CNT,
        PH_DUP_CNT,
        PH_DUP_VAL
    } t_phase;

    // One unclipped span or a done marker, in sprite-local coordinates.
    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [LEN_W-1:0] len;
        logic [PIX_W-1:0] pix;
    } t_cmd;

    typedef struct packed {
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
        logic [WIN_W-1:0]        window_width;
        logic [WIN_W-1:0]        window_height;
        logic [SROWS_W-1:0]      sprite_rows;
        logic                    mono_enable;
        logic [PIX_W-1:0]        mono_colour;
    } t_cfg;

endpackage

// ===== hdl/rscd_front.sv =====
// Stream parser: tracks the sprite cursor and issues span commands.
module rscd_front import rscd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    t_phase           r_phase, n_phase;
    logic [RUN_W-1:0] r_run, n_run;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [RUN_W-1:0] w_byte_p1;
    logic [RUN_W-1:0] w_run_m1;
    logic [RUN_W-1:0] w_col_add;
    logic [COL_W:0]   w_col_sum;
    logic [COL_W-1:0] w_col_sat;

    assign w_byte_p1 = {1'b0, i_byte} + RUN_W'(1);
    assign w_run_m1  = r_run - RUN_W'(1);

    always_comb begin
        case (r_phase)
            PH_SKIP_CNT: w_col_add = w_byte_p1;
            PH_DUP_VAL:  w_col_add = r_run;
            default:     w_col_add = RUN_W'(1);
        endcase
    end

    assign w_col_sum = {1'b0, r_col} + (COL_W + 1)'(w_col_add);
    assign w_col_sat = w_col_sum[COL_W] ? COL_MAX : w_col_sum[COL_W-1:0];

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_col   = r_col;
        n_row   = r_row;
        if (i_accept) begin
            case (r_phase)
                PH_COPY_CNT: begin
                    n_run   = w_byte_p1;
                    n_phase = PH_COPY_DATA;
                end
                PH_COPY_DATA: begin
                    n_col = w_col_sat;
                    n_run = w_run_m1;
                    if (w_run_m1 == '0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_SKIP_CNT: begin
                    n_col   = w_col_sat;
                    n_phase = PH_OPCODE;
                end
                PH_DUP_CNT: begin
                    n_run   = w_byte_p1;
                    n_phase = PH_DUP_VAL;
                end
                PH_DUP_VAL: begin
                    n_col   = w_col_sat;
                    n_run   = '0;
                    n_phase = PH_OPCODE;
                end
                default: begin
                    n_phase = PH_OPCODE;
                    case (i_byte)
                        OP_FINISHED: begin
                            n_run = '0;
                            n_col = '0;
                            n_row = '0;
                        end
                        OP_END_LINE: begin
                            n_col = '0;
                            if (r_row != ROW_MAX) begin
                                n_row = r_row + ROW_W'(1);
                            end
                        end
                        OP_COPY:      n_phase = PH_COPY_CNT;
                        OP_SKIP:      n_phase = PH_SKIP_CNT;
                        OP_DUPLICATE: n_phase = PH_DUP_CNT;
                        default: ;
                    endcase
                end
            endcase
        end
    end

    // Command outputs.
    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd.done  = 1'b0;
        o_cmd.col   = r_col;
        o_cmd.row   = r_row;
        o_cmd.len   = LEN_W'(1);
        o_cmd.pix   = i_byte;
        case (r_phase)
            PH_COPY_DATA: begin
                o_cmd_valid = i_accept;
            end
            PH_DUP_VAL: begin
                o_cmd_valid = i_accept;
                o_cmd.len   = r_run;
            end
            PH_OPCODE: begin
                if (i_byte == OP_FINISHED) begin
                    o_cmd_valid = i_accept;
                    o_cmd.done  = 1'b1;
                    o_cmd.col   = '0;
                    o_cmd.row   = '0;
                    o_cmd.len   = '0;
                    o_cmd.pix   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_run   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

// ===== hdl/rscd_queue.sv =====
// Short command queue between the parser and the clipping stage.
module rscd_queue import rscd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers wrap on their own since the depth is a power of two.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/rscd_back.sv =====
// Clipping stage: maps commands to screen spans and holds the result register.
module rscd_back import rscd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_span_column,
    output logic [COORD_BITS-1:0] o_span_row,
    output logic [LEN_W-1:0]      o_span_length,
    output logic [PIX_W-1:0]      o_pixel_value,
    output logic                  o_done_res
);

    logic                  r_valid, n_valid;
    logic [COORD_BITS-1:0] r_col, r_row;
    logic [LEN_W-1:0]      r_len;
    logic [PIX_W-1:0]      r_pix;
    logic                  r_done;

    logic signed [ARITH_W-1:0] w_ww_raw, w_wh_raw, w_ww, w_wh;
    logic signed [ARITH_W-1:0] w_org_x, w_org_y;
    logic signed [ARITH_W-1:0] w_srow, w_start, w_end, w_start_c, w_end_c, w_len;
    logic                      w_row_vis, w_vis;

    assign w_ww_raw = $signed({{(ARITH_W - WIN_W){1'b0}}, i_cfg.window_width});
    assign w_wh_raw = $signed({{(ARITH_W - WIN_W){1'b0}}, i_cfg.window_height});
    assign w_ww     = (w_ww_raw > COORD_CAP) ? COORD_CAP : w_ww_raw;
    assign w_wh     = (w_wh_raw > COORD_CAP) ? COORD_CAP : w_wh_raw;

    assign w_org_x = $signed({{(ARITH_W - ORG_W){i_cfg.origin_x[ORG_W-1]}}, i_cfg.origin_x});
    assign w_org_y = $signed({{(ARITH_W - ORG_W){i_cfg.origin_y[ORG_W-1]}}, i_cfg.origin_y});

    assign w_srow  = w_org_y + $signed({{(ARITH_W - ROW_W){1'b0}}, i_cmd.row});
    assign w_start = w_org_x + $signed({{(ARITH_W - COL_W){1'b0}}, i_cmd.col});
    assign w_end   = w_start + $signed({{(ARITH_W - LEN_W){1'b0}}, i_cmd.len});

    assign w_row_vis = (i_cmd.row < i_cfg.sprite_rows) && !w_srow[ARITH_W-1]
                       && (w_srow < w_wh);

    assign w_start_c = w_start[ARITH_W-1] ? '0 : w_start;
    assign w_end_c   = (w_end > w_ww) ? w_ww : w_end;
    assign w_len     = w_end_c - w_start_c;
    assign w_vis     = i_cmd.done || (w_row_vis && (w_start_c < w_end_c));

    // Take a command whenever the result register is empty or being emptied.
    assign o_pop = i_cmd_valid && (!r_valid || !i_out_stall);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = w_vis;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_done <= i_cmd.done;
            if (i_cmd.done) begin
                r_col <= '0;
                r_row <= '0;
                r_len <= '0;
                r_pix <= '0;
            end else begin
                r_col <= w_start_c[COORD_BITS-1:0];
                r_row <= w_srow[COORD_BITS-1:0];
                r_len <= w_len[LEN_W-1:0];
                r_pix <= i_cfg.mono_enable ? i_cfg.mono_colour : i_cmd.pix;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_span_column = r_col;
    assign o_span_row    = r_row;
    assign o_span_length = r_len;
    assign o_pixel_value = r_pix;
    assign o_done_res    = r_done;

endmodule

// ===== hdl/rle_sprite_clip_decoder_top.sv =====
// Top level of the run-length sprite clip decoder with its register file.
//
//  Channel  Direction  Handshake                Payload
//  input    in         i_in_valid / o_in_stall  i_sprite_byte
//  output   out        o_out_valid / i_out_stall span_column, span_row, span_length,
//                                               pixel_value, done_res
//  config   in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One sprite byte is taken per cycle while o_in_stall is low; a span or done beat
// for that byte passes through the command queue and then the result register.
// The four-entry command queue sets how many span bytes can be taken while the
// output side stalls; o_in_stall rises only when that queue is full.
// Reset is synchronous and active low; no clearing pass is needed after it.
module rle_sprite_clip_decoder_top import rscd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_sprite_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_span_column,
    output logic [COORD_BITS-1:0] o_span_row,
    output logic [LEN_W-1:0]      o_span_length,
    output logic [PIX_W-1:0]      o_pixel_value,
    output logic                  o_done_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       r_cfg;
    logic       w_cfg_wr;
    logic [2:0] w_reg_idx;

    logic w_accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_q_full, w_q_valid, w_pop;
    t_cmd w_q_cmd;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.window_width  <= WIN_W'(640);
            r_cfg.window_height <= WIN_W'(480);
            r_cfg.sprite_rows   <= '0;
            r_cfg.mono_enable   <= 1'b0;
            r_cfg.mono_colour   <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_ORIGIN_X:      r_cfg.origin_x      <= $signed(pwdata[ORG_W-1:0]);
                REG_ORIGIN_Y:      r_cfg.origin_y      <= $signed(pwdata[ORG_W-1:0]);
                REG_WINDOW_WIDTH:  r_cfg.window_width  <= pwdata[WIN_W-1:0];
                REG_WINDOW_HEIGHT: r_cfg.window_height <= pwdata[WIN_W-1:0];
                REG_SPRITE_ROWS:   r_cfg.sprite_rows   <= pwdata[SROWS_W-1:0];
                REG_MONO_ENABLE:   r_cfg.mono_enable   <= pwdata[0];
                REG_MONO_COLOUR:   r_cfg.mono_colour   <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_ORIGIN_X:      prdata = APB_DATA_W'(unsigned'(r_cfg.origin_x));
            REG_ORIGIN_Y:      prdata = APB_DATA_W'(unsigned'(r_cfg.origin_y));
            REG_WINDOW_WIDTH:  prdata = APB_DATA_W'(r_cfg.window_width);
            REG_WINDOW_HEIGHT: prdata = APB_DATA_W'(r_cfg.window_height);
            REG_SPRITE_ROWS:   prdata = APB_DATA_W'(r_cfg.sprite_rows);
            REG_MONO_ENABLE:   prdata = APB_DATA_W'(r_cfg.mono_enable);
            REG_MONO_COLOUR:   prdata = APB_DATA_W'(r_cfg.mono_colour);
            default:           prdata = '0;
        endcase
    end

    assign o_in_stall = w_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    rscd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_sprite_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    rscd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    rscd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (w_q_valid),
        .i_cmd         (w_q_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_span_column (o_span_column),
        .o_span_row    (o_span_row),
        .o_span_length (o_span_length),
        .o_pixel_value (o_pixel_value),
        .o_done_res    (o_done_res)
    );

`ifndef SYNTHESIS
    // A done beat carries no span.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_span_length == '0 && o_span_column == '0
                                         && o_span_row == '0))
        else $error("done beat carries span data");

    // A span beat is never empty and never longer than one duplicate run.
    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_span_length != '0
                                          && o_span_length <= LEN_W'(256)))
        else $error("span beat length out of range");

    // A span that is clipped to the window ends inside the coordinate range.
    a_span_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |->
            (({1'b0, o_span_column} + (COORD_BITS + 1)'(o_span_length))
             <= (COORD_BITS + 1)'(1 << COORD_BITS)))
        else $error("span runs past the coordinate range");
`endif

endmodule
